>>> rtl/ray_obb_slab_intersect_unit_defines.svh
// Assertion macros shared by the slab test RTL.
// Each check is clocked on clk and disabled while arst_n is low.
`ifndef RAY_OBB_SLAB_INTERSECT_UNIT_DEFINES_SVH
`define RAY_OBB_SLAB_INTERSECT_UNIT_DEFINES_SVH
`ifndef SYNTH
`define ROSI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rosi: same-cycle check failed");
`define ROSI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rosi: next-cycle check failed");
`else
`define ROSI_ASSERT_IMP(lbl, ante, cons)
`define ROSI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/rosi_pkg.sv
`default_nettype none
package rosi_pkg;

	localparam int COMPONENT_WIDTH = 16;
	localparam int W        = COMPONENT_WIDTH;
	localparam int PACKED_W = 3 * W;
	localparam int FRAC_SH  = 14;
	localparam int D_W      = W + 1;
	localparam int PE_W     = W + D_W;
	localparam int PF_W     = 2 * W;
	localparam int E_W      = PE_W + 2;
	localparam int F_W      = PF_W + 2;
	localparam int LO_W     = W + FRAC_SH;
	localparam int SUM_W    = ((E_W > LO_W) ? E_W : LO_W) + 1;
	localparam int N_W      = SUM_W + FRAC_SH;
	localparam int Q_W      = 32;
	localparam int REM_W    = F_W;
	localparam int FAR_W    = 31;
	localparam int THR_W    = 15;
	localparam int PAR_W    = ((F_W > THR_W + FRAC_SH) ? F_W : THR_W + FRAC_SH);
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = FAR_W;

	localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAR_THR   = 1'b1;

	localparam logic [FAR_W-1:0] FAR_RESET = 31'd25600000;
	localparam logic [THR_W-1:0] THR_RESET = 15'd16;

	localparam logic signed [31:0] DIST_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] DIST_MIN = 32'sh8000_0000;

	typedef logic signed [W-1:0]     comp_t;
	typedef logic signed [D_W-1:0]   delta_t;
	typedef logic signed [PE_W-1:0]  prod_e_t;
	typedef logic signed [PF_W-1:0]  prod_f_t;
	typedef logic signed [E_W-1:0]   e_t;
	typedef logic signed [F_W-1:0]   f_t;
	typedef logic signed [LO_W-1:0]  lo_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [N_W-1:0]   n_t;
	typedef logic [N_W-1:0]          mag_t;
	typedef logic [REM_W-1:0]        rem_t;
	typedef logic [PAR_W-1:0]        par_t;
	typedef logic [Q_W-1:0]          q_t;
	typedef logic signed [31:0]      dist_t;

	typedef struct packed {
		logic [PACKED_W-1:0] ray_origin_packed;
		logic [PACKED_W-1:0] ray_direction_packed;
		logic [PACKED_W-1:0] box_center_packed;
		logic [PACKED_W-1:0] box_axis_x_packed;
		logic [PACKED_W-1:0] box_axis_y_packed;
		logic [PACKED_W-1:0] box_axis_z_packed;
		logic [PACKED_W-1:0] box_low_corner_packed;
		logic [PACKED_W-1:0] box_high_corner_packed;
		logic signed [31:0]  best_distance;
	} in_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] entry_distance;
		logic               closer;
		logic signed [31:0] new_best_distance;
	} out_t;

	// Per-item flags that ride alongside the dividers; quotient k of axis a is 2a+k.
	typedef struct packed {
		logic [2:0]  par;
		logic [2:0]  pmiss;
		logic [5:0]  neg;
		logic [5:0]  ovf;
		dist_t       best;
	} side_t;

endpackage
`default_nettype wire

>>> rtl/rosi_front.sv
`default_nettype none
module rosi_front (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  en,
	input  wire logic                                  in_valid,
	input  wire rosi_pkg::in_t                         in_data,
	input  wire logic [rosi_pkg::THR_W-1:0]            thr,
	output logic                                       v_o,
	output logic [5:0][rosi_pkg::N_W-1:0]              mag,
	output logic [2:0][rosi_pkg::F_W-1:0]              dvs,
	output rosi_pkg::side_t                            side
);

	rosi_pkg::delta_t  delta_c [3];
	rosi_pkg::comp_t   dir_c [3];
	rosi_pkg::comp_t   ax_c [3][3];
	rosi_pkg::comp_t   lo_c [3];
	rosi_pkg::comp_t   hi_c [3];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	rosi_pkg::delta_t  delta_s1 [3];
	rosi_pkg::comp_t   dir_s1 [3];
	rosi_pkg::comp_t   ax_s1 [3][3];
	rosi_pkg::comp_t   lo_s1 [3];
	rosi_pkg::comp_t   hi_s1 [3];
	rosi_pkg::dist_t   best_s1;

	rosi_pkg::prod_e_t pe_s2 [3][3];
	rosi_pkg::prod_f_t pf_s2 [3][3];
	rosi_pkg::comp_t   lo_s2 [3];
	rosi_pkg::comp_t   hi_s2 [3];
	rosi_pkg::dist_t   best_s2;

	rosi_pkg::e_t      e_s3 [3];
	rosi_pkg::f_t      f_s3 [3];
	rosi_pkg::lo_t     lo_s3 [3];
	rosi_pkg::lo_t     hi_s3 [3];
	rosi_pkg::dist_t   best_s3;

	logic [rosi_pkg::F_W-1:0] af_c [3];
	rosi_pkg::sum_t    sum_s4 [6];
	logic [rosi_pkg::F_W-1:0] af_s4 [3];
	logic [2:0]        fneg_s4;
	logic [2:0]        par_s4;
	logic [2:0]        pmiss_s4;
	rosi_pkg::dist_t   best_s4;

	rosi_pkg::n_t      n_c [6];
	rosi_pkg::mag_t    mag_c [6];
	rosi_pkg::mag_t    mag_s5 [6];
	logic [rosi_pkg::F_W-1:0] af_s5 [3];
	logic [5:0]        neg_s5;
	logic [5:0]        ovf_s5;
	logic [2:0]        par_s5;
	logic [2:0]        pmiss_s5;
	rosi_pkg::dist_t   best_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			delta_c[i] = rosi_pkg::delta_t'($signed(
					in_data.box_center_packed[i*rosi_pkg::W +: rosi_pkg::W]))
				- rosi_pkg::delta_t'($signed(
					in_data.ray_origin_packed[i*rosi_pkg::W +: rosi_pkg::W]));
			dir_c[i]   = $signed(in_data.ray_direction_packed[i*rosi_pkg::W +: rosi_pkg::W]);
			ax_c[0][i] = $signed(in_data.box_axis_x_packed[i*rosi_pkg::W +: rosi_pkg::W]);
			ax_c[1][i] = $signed(in_data.box_axis_y_packed[i*rosi_pkg::W +: rosi_pkg::W]);
			ax_c[2][i] = $signed(in_data.box_axis_z_packed[i*rosi_pkg::W +: rosi_pkg::W]);
			lo_c[i]    = $signed(in_data.box_low_corner_packed[i*rosi_pkg::W +: rosi_pkg::W]);
			hi_c[i]    = $signed(in_data.box_high_corner_packed[i*rosi_pkg::W +: rosi_pkg::W]);
		end
	end

	// Absolute projected direction and the plane numerators (e + corner) shifted by 14.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			af_c[a] = f_s3[a][rosi_pkg::F_W-1] ? (~f_s3[a] + 1'b1) : f_s3[a];
		end
		for (int k = 0; k < 6; k++) begin
			n_c[k]   = rosi_pkg::n_t'(sum_s4[k]) <<< rosi_pkg::FRAC_SH;
			mag_c[k] = n_c[k][rosi_pkg::N_W-1] ? (~n_c[k] + 1'b1) : n_c[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				delta_s1[i] <= delta_c[i];
				dir_s1[i]   <= dir_c[i];
				lo_s1[i]    <= lo_c[i];
				hi_s1[i]    <= hi_c[i];
				for (int a = 0; a < 3; a++) begin
					ax_s1[a][i] <= ax_c[a][i];
				end
			end
			best_s1 <= in_data.best_distance;

			for (int a = 0; a < 3; a++) begin
				for (int i = 0; i < 3; i++) begin
					pe_s2[a][i] <= ax_s1[a][i] * delta_s1[i];
					pf_s2[a][i] <= ax_s1[a][i] * dir_s1[i];
				end
				lo_s2[a] <= lo_s1[a];
				hi_s2[a] <= hi_s1[a];
			end
			best_s2 <= best_s1;

			for (int a = 0; a < 3; a++) begin
				e_s3[a]  <= rosi_pkg::e_t'(pe_s2[a][0]) + rosi_pkg::e_t'(pe_s2[a][1])
					+ rosi_pkg::e_t'(pe_s2[a][2]);
				f_s3[a]  <= rosi_pkg::f_t'(pf_s2[a][0]) + rosi_pkg::f_t'(pf_s2[a][1])
					+ rosi_pkg::f_t'(pf_s2[a][2]);
				lo_s3[a] <= rosi_pkg::lo_t'(lo_s2[a]) <<< rosi_pkg::FRAC_SH;
				hi_s3[a] <= rosi_pkg::lo_t'(hi_s2[a]) <<< rosi_pkg::FRAC_SH;
			end
			best_s3 <= best_s2;

			for (int a = 0; a < 3; a++) begin
				sum_s4[2*a]   <= rosi_pkg::sum_t'(e_s3[a]) + rosi_pkg::sum_t'(lo_s3[a]);
				sum_s4[2*a+1] <= rosi_pkg::sum_t'(e_s3[a]) + rosi_pkg::sum_t'(hi_s3[a]);
				af_s4[a]      <= af_c[a];
				fneg_s4[a]    <= f_s3[a][rosi_pkg::F_W-1];
				par_s4[a]     <= rosi_pkg::par_t'(af_c[a])
					<= (rosi_pkg::par_t'(thr) << rosi_pkg::FRAC_SH);
				pmiss_s4[a]   <= (rosi_pkg::sum_t'(lo_s3[a]) > rosi_pkg::sum_t'(e_s3[a]))
					|| (rosi_pkg::sum_t'(hi_s3[a]) < rosi_pkg::sum_t'(e_s3[a]));
			end
			best_s4 <= best_s3;

			for (int k = 0; k < 6; k++) begin
				mag_s5[k] <= mag_c[k];
				neg_s5[k] <= n_c[k][rosi_pkg::N_W-1] ^ fneg_s4[k/2];
				ovf_s5[k] <= rosi_pkg::rem_t'(mag_c[k][rosi_pkg::N_W-1:rosi_pkg::Q_W])
					>= af_s4[k/2];
			end
			for (int a = 0; a < 3; a++) begin
				af_s5[a] <= af_s4[a];
			end
			par_s5   <= par_s4;
			pmiss_s5 <= pmiss_s4;
			best_s5  <= best_s4;
		end
	end

	always_comb begin
		v_o = v_s5;
		for (int k = 0; k < 6; k++) begin
			mag[k] = mag_s5[k];
		end
		for (int a = 0; a < 3; a++) begin
			dvs[a] = af_s5[a];
		end
		side.par   = par_s5;
		side.pmiss = pmiss_s5;
		side.neg   = neg_s5;
		side.ovf   = ovf_s5;
		side.best  = best_s5;
	end

endmodule
`default_nettype wire

>>> rtl/rosi_div.sv
`default_nettype none
module rosi_div (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [rosi_pkg::N_W-1:0]      mag,
	input  wire logic                          ovf,
	input  wire logic [rosi_pkg::F_W-1:0]      dvs,
	output logic [rosi_pkg::Q_W-1:0]           q
);

	// Restoring division, one quotient bit per stage, most significant first.
	rosi_pkg::rem_t rem_c [rosi_pkg::Q_W];
	rosi_pkg::q_t   low_c [rosi_pkg::Q_W];
	rosi_pkg::q_t   quo_c [rosi_pkg::Q_W];
	rosi_pkg::rem_t dvs_c [rosi_pkg::Q_W];
	logic [rosi_pkg::REM_W:0] trial_c [rosi_pkg::Q_W];
	logic           ge_c [rosi_pkg::Q_W];
	rosi_pkg::rem_t rem_n [rosi_pkg::Q_W];

	rosi_pkg::rem_t rem_s [rosi_pkg::Q_W];
	rosi_pkg::q_t   low_s [rosi_pkg::Q_W];
	rosi_pkg::q_t   quo_s [rosi_pkg::Q_W];
	rosi_pkg::rem_t dvs_s [rosi_pkg::Q_W];

	always_comb begin
		rem_c[0] = ovf ? '0 : rosi_pkg::rem_t'(mag[rosi_pkg::N_W-1:rosi_pkg::Q_W]);
		low_c[0] = mag[rosi_pkg::Q_W-1:0];
		quo_c[0] = '0;
		dvs_c[0] = dvs;
		for (int k = 1; k < rosi_pkg::Q_W; k++) begin
			rem_c[k] = rem_s[k-1];
			low_c[k] = low_s[k-1];
			quo_c[k] = quo_s[k-1];
			dvs_c[k] = dvs_s[k-1];
		end
		for (int k = 0; k < rosi_pkg::Q_W; k++) begin
			trial_c[k] = {rem_c[k], low_c[k][rosi_pkg::Q_W-1]};
			ge_c[k]    = trial_c[k] >= {1'b0, dvs_c[k]};
			rem_n[k]   = ge_c[k] ? rosi_pkg::rem_t'(trial_c[k] - {1'b0, dvs_c[k]})
				: rosi_pkg::rem_t'(trial_c[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < rosi_pkg::Q_W; k++) begin
				rem_s[k] <= rem_n[k];
				low_s[k] <= low_c[k] << 1;
				quo_s[k] <= {quo_c[k][rosi_pkg::Q_W-2:0], ge_c[k]};
				dvs_s[k] <= dvs_c[k];
			end
		end
	end

	assign q = quo_s[rosi_pkg::Q_W-1];

endmodule
`default_nettype wire

>>> rtl/rosi_clip.sv
`default_nettype none
module rosi_clip (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [5:0][rosi_pkg::Q_W-1:0] q,
	input  wire rosi_pkg::side_t               side,
	input  wire logic [rosi_pkg::FAR_W-1:0]    far_limit,
	output logic                               out_valid,
	output rosi_pkg::out_t                     out_data
);

	// Signed quotient from magnitude, sign and overflow, clamped to the distance range.
	function automatic rosi_pkg::dist_t sat_div(input logic [rosi_pkg::Q_W-1:0] qm,
			input logic neg, input logic ovf);
		rosi_pkg::dist_t r;
		if (neg) begin
			r = (ovf || (qm > rosi_pkg::Q_W'(rosi_pkg::DIST_MIN))) ? rosi_pkg::DIST_MIN
				: -$signed(qm);
		end else begin
			r = (ovf || qm[rosi_pkg::Q_W-1]) ? rosi_pkg::DIST_MAX : $signed(qm);
		end
		return r;
	endfunction

	rosi_pkg::dist_t t_c [6];
	rosi_pkg::dist_t tmin_c, tmax_c;
	logic            hit_c;

	logic            v_sA, v_sB;
	rosi_pkg::dist_t tn_sA [3];
	rosi_pkg::dist_t tx_sA [3];
	logic [2:0]      std_sA;
	logic            pm_sA;
	rosi_pkg::dist_t best_sA;

	rosi_pkg::dist_t tmin_sB, tmax_sB;
	logic            pm_sB;
	rosi_pkg::dist_t best_sB;

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			t_c[k] = sat_div(q[k], side.neg[k], side.ovf[k]);
		end
	end

	// Tighten [0, far] by each non-parallel axis.
	always_comb begin
		tmax_c = $signed({1'b0, far_limit});
		tmin_c = '0;
		for (int a = 0; a < 3; a++) begin
			if (std_sA[a] && (tx_sA[a] < tmax_c)) begin
				tmax_c = tx_sA[a];
			end
			if (std_sA[a] && (tn_sA[a] > tmin_c)) begin
				tmin_c = tn_sA[a];
			end
		end
		hit_c = !pm_sB && (tmax_sB >= tmin_sB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sA      <= 1'b0;
			v_sB      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_sA      <= in_valid;
			v_sB      <= v_sA;
			out_valid <= v_sB;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				tn_sA[a]  <= (t_c[2*a] < t_c[2*a+1]) ? t_c[2*a] : t_c[2*a+1];
				tx_sA[a]  <= (t_c[2*a] < t_c[2*a+1]) ? t_c[2*a+1] : t_c[2*a];
				std_sA[a] <= !side.par[a];
			end
			pm_sA   <= |(side.par & side.pmiss);
			best_sA <= side.best;

			tmin_sB <= tmin_c;
			tmax_sB <= tmax_c;
			pm_sB   <= pm_sA;
			best_sB <= best_sA;

			out_data.hit               <= hit_c;
			out_data.entry_distance    <= hit_c ? tmin_sB : '0;
			out_data.closer            <= hit_c && (tmin_sB < best_sB);
			out_data.new_best_distance <= (hit_c && (tmin_sB < best_sB)) ? tmin_sB : best_sB;
		end
	end

endmodule
`default_nettype wire

>>> rtl/ray_obb_slab_intersect_unit.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall   | in_data  (ray, box, best distance)
// out     | output    | out_valid / out_stall | out_data (hit, entry, closer, new best)
// cfg     | input     | cfg_we                | cfg_index, cfg_wdata
//
// One ray/box pair is accepted every cycle while in_stall is low.
// The six 32-stage restoring dividers produce one quotient bit per stage.
// The whole pipeline advances together; when a result is held by out_stall the
// pipeline freezes and in_stall rises in the same cycle.
// Reset clears the valid bits and sets far_limit and parallel_threshold to their defaults.
`default_nettype none
`include "ray_obb_slab_intersect_unit_defines.svh"
module ray_obb_slab_intersect_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire rosi_pkg::in_t                       in_data,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output rosi_pkg::out_t                           out_data,
	input  wire logic                                cfg_we,
	input  wire logic [rosi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rosi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	logic                           en;
	logic [rosi_pkg::FAR_W-1:0]     far_limit_q;
	logic [rosi_pkg::THR_W-1:0]     par_thr_q;

	logic                           front_v;
	logic [5:0][rosi_pkg::N_W-1:0]  front_mag;
	logic [2:0][rosi_pkg::F_W-1:0]  front_dvs;
	rosi_pkg::side_t                front_side;

	logic [5:0][rosi_pkg::Q_W-1:0]  quo;
	rosi_pkg::side_t                side_d [rosi_pkg::Q_W];
	logic [rosi_pkg::Q_W-1:0]       vld_d;

	// The pipeline moves unless a finished item sits in the output register unaccepted.
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			far_limit_q <= rosi_pkg::FAR_RESET;
			par_thr_q   <= rosi_pkg::THR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rosi_pkg::CFG_FAR_LIMIT: far_limit_q <= cfg_wdata;
				rosi_pkg::CFG_PAR_THR:   par_thr_q   <= cfg_wdata[rosi_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Projection, plane numerators and parallel tests.
	rosi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_data  (in_data),
		.thr      (par_thr_q),
		.v_o      (front_v),
		.mag      (front_mag),
		.dvs      (front_dvs),
		.side     (front_side)
	);

	// Low-corner and high-corner plane distance for each of the three axes.
	for (genvar k = 0; k < 6; k++) begin : g_div
		rosi_div u_div (
			.clk (clk),
			.en  (en),
			.mag (front_mag[k]),
			.ovf (front_side.ovf[k]),
			.dvs (front_dvs[k/2]),
			.q   (quo[k])
		);
	end

	// Flags and best distance wait beside the dividers so they line up with the quotients.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d <= '0;
		end else if (en) begin
			vld_d <= {vld_d[rosi_pkg::Q_W-2:0], front_v};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= front_side;
			for (int k = 1; k < rosi_pkg::Q_W; k++) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	// Saturation, ordering, interval clipping and the best-distance compare.
	rosi_clip u_clip (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_d[rosi_pkg::Q_W-1]),
		.q         (quo),
		.side      (side_d[rosi_pkg::Q_W-1]),
		.far_limit (far_limit_q),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// A miss reports a zero entry and leaves the best distance alone.
	`ROSI_ASSERT_IMP(a_miss_clean, out_valid && !out_data.hit, (out_data.entry_distance == 0) && !out_data.closer)
	// A closer result must be a hit whose entry becomes the new best.
	`ROSI_ASSERT_IMP(a_closer_hit, out_valid && out_data.closer, out_data.hit && (out_data.new_best_distance == out_data.entry_distance))
	// The entry of a hit lies within [0, far_limit].
	`ROSI_ASSERT_IMP(a_entry_range, out_valid && out_data.hit, (out_data.entry_distance >= 0) && (out_data.entry_distance <= $signed({1'b0, far_limit_q})))
	// A frozen pipeline keeps its output item.
	`ROSI_ASSERT_NXT(a_freeze_hold, !en, out_valid && $stable(out_data))

endmodule
`default_nettype wire

>>> tb/sv/slab_result_checker.sv
`timescale 1ns / 1ps
// Watches all three channels of the slab test unit. It predicts each result from the
// accepted ray/box pair and compares it with what the unit delivers.
module slab_result_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire rosi_pkg::in_t                 in_data,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire rosi_pkg::out_t                out_data,
	input  wire logic                          cfg_we,
	input  wire logic [rosi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rosi_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                                 fail_count,
	output int                                 pending,
	output int                                 hits_seen,
	output int                                 results_seen
);
	import rosi_pkg::*;

	localparam longint SCALE = 64'sd16384;

	logic [FAR_W-1:0] far_reg;
	logic [THR_W-1:0] thr_reg;
	out_t expected_q[$];

	function automatic longint field(input logic [PACKED_W-1:0] v, input int i);
		comp_t c;
		c = v[i*W +: W];
		return longint'(c);
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic out_t slab_test(input in_t p, input logic [FAR_W-1:0] far_v,
		input logic [THR_W-1:0] thr_v);
		longint d[3], r[3], e, f, lo, hi, af, t1, t2, tnear, tfar, lim, best, sw;
		logic [PACKED_W-1:0] ax;
		bit in_box, nearer;
		out_t o;
		tnear = 0;
		tfar = longint'(far_v);
		lim = longint'(thr_v) * SCALE;
		in_box = 1;
		best = longint'(p.best_distance);
		for (int i = 0; i < 3; i++) begin
			d[i] = field(p.box_center_packed, i) - field(p.ray_origin_packed, i);
			r[i] = field(p.ray_direction_packed, i);
		end
		for (int a = 0; a < 3; a++) begin
			ax = (a == 0) ? p.box_axis_x_packed :
				(a == 1) ? p.box_axis_y_packed : p.box_axis_z_packed;
			e = field(ax, 0) * d[0] + field(ax, 1) * d[1] + field(ax, 2) * d[2];
			f = field(ax, 0) * r[0] + field(ax, 1) * r[1] + field(ax, 2) * r[2];
			lo = field(p.box_low_corner_packed, a) * SCALE;
			hi = field(p.box_high_corner_packed, a) * SCALE;
			af = (f < 0) ? -f : f;
			if (af > lim) begin
				// SystemVerilog integer division truncates toward zero.
				t1 = clamp32(((e + lo) * SCALE) / f);
				t2 = clamp32(((e + hi) * SCALE) / f);
				if (t1 > t2) begin
					sw = t1;
					t1 = t2;
					t2 = sw;
				end
				if (t2 < tfar)
					tfar = t2;
				if (t1 > tnear)
					tnear = t1;
				if (tfar < tnear)
					in_box = 0;
			end else if (lo > e || hi < e) begin
				in_box = 0;
			end
		end
		if (!in_box)
			tnear = 0;
		nearer = in_box && (tnear < best);
		o.hit = in_box;
		o.entry_distance = tnear[31:0];
		o.closer = nearer;
		o.new_best_distance = nearer ? tnear[31:0] : best[31:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t exp_r;
		if (!arst_n) begin
			far_reg <= FAR_RESET;
			thr_reg <= THR_RESET;
			fail_count <= 0;
			hits_seen <= 0;
			results_seen <= 0;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_FAR_LIMIT)
					far_reg <= cfg_wdata[FAR_W-1:0];
				else
					thr_reg <= cfg_wdata[THR_W-1:0];
			end
			if (in_valid && !in_stall)
				expected_q.push_back(slab_test(in_data, far_reg, thr_reg));
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (out_data.hit)
					hits_seen <= hits_seen + 1;
				if (expected_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("ERROR: unexpected result %p", out_data);
				end else begin
					exp_r = expected_q.pop_front();
					if (exp_r !== out_data) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("ERROR: result mismatch exp %p got %p", exp_r, out_data);
					end
				end
			end
		end
	end

	assign pending = expected_q.size();
endmodule

>>> tb/sv/tb_ray_obb_slab_intersect_unit.sv
`timescale 1ns / 1ps
// Stimulus for the ray versus oriented box slab test unit. The checker beside
// the unit does all prediction and comparison; this module only drives items and
// stalls, writes the two registers between phases and gives the verdict.
module tb_ray_obb_slab_intersect_unit;
	import rosi_pkg::*;

	localparam int LATENCY = 40;
	localparam int RANDOM_ITEMS = 1950;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int fail_count, pending, hits_seen, results_seen;
	int hold_cycles;
	bit quiet_tail;
	bit hold_req;
	longint cycle_count;

	ray_obb_slab_intersect_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	slab_result_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending),
		.hits_seen(hits_seen), .results_seen(results_seen)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// A run that hangs is cut off here.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("ERROR: timeout after %0d cycles", cycle_count);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// The receiver stalls in random short bursts. When the stimulus
	// asks for it, it holds off for one long stretch so that the pipeline fills
	// and the unit pushes back on its input.
	initial begin
		int n;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1;
				for (hold_cycles = 0; hold_cycles < 120; hold_cycles++)
					@(negedge clk);
				out_stall <= 0;
				hold_req = 0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 4);
				out_stall <= 1;
				repeat (n) @(negedge clk);
				out_stall <= 0;
			end
		end
	end

	function automatic logic [PACKED_W-1:0] pack3(input int x, input int y, input int z);
		comp_t a, b, c;
		a = x;
		b = y;
		c = z;
		return {c, b, a};
	endfunction

	function automatic logic [PACKED_W-1:0] rand_wide();
		return {$urandom(), $urandom()};
	endfunction

	// A unit vector along one world axis, possibly negated, in Q1.14.
	function automatic logic [PACKED_W-1:0] unit_axis(input int k, input int sgn);
		int v;
		v = sgn * 16384;
		return (k == 0) ? pack3(v, 0, 0) : (k == 1) ? pack3(0, v, 0) : pack3(0, 0, v);
	endfunction

	// Most random items are boxes near the ray with sensible axes so that hits,
	// misses and parallel axes all occur; the rest are raw noise.
	function automatic in_t make_pair();
		in_t p;
		int lx, ly, lz, s;
		s = $urandom_range(0, 9);
		if (s < 2) begin
			p.ray_origin_packed = rand_wide();
			p.ray_direction_packed = rand_wide();
			p.box_center_packed = rand_wide();
			p.box_axis_x_packed = rand_wide();
			p.box_axis_y_packed = rand_wide();
			p.box_axis_z_packed = rand_wide();
			p.box_low_corner_packed = rand_wide();
			p.box_high_corner_packed = rand_wide();
		end else begin
			p.ray_origin_packed = pack3($urandom_range(0, 4096) - 2048,
				$urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048);
			p.ray_direction_packed = ($urandom_range(0, 3) == 0) ?
				unit_axis($urandom_range(0, 2), $urandom_range(0, 1) ? 1 : -1) :
				pack3($urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
					$urandom_range(0, 32767) - 16384);
			p.box_center_packed = pack3($urandom_range(0, 8192) - 4096,
				$urandom_range(0, 8192) - 4096, $urandom_range(0, 8192) - 4096);
			if (s < 7) begin
				p.box_axis_x_packed = unit_axis(0, 1);
				p.box_axis_y_packed = unit_axis(1, 1);
				p.box_axis_z_packed = unit_axis(2, 1);
			end else begin
				p.box_axis_x_packed = pack3(11585, 11585, 0);
				p.box_axis_y_packed = pack3(-11585, 11585, 0);
				p.box_axis_z_packed = unit_axis(2, $urandom_range(0, 1) ? 1 : -1);
			end
			lx = $urandom_range(0, 2048);
			ly = $urandom_range(0, 2048);
			lz = $urandom_range(0, 2048);
			p.box_low_corner_packed = pack3(-lx, -ly, -lz);
			p.box_high_corner_packed = ($urandom_range(0, 15) == 0) ?
				pack3(-lx - 256, ly, lz) : pack3(lx, ly, lz);
		end
		case ($urandom_range(0, 3))
			0: p.best_distance = $urandom();
			1: p.best_distance = DIST_MAX;
			default: p.best_distance = $urandom_range(0, 1 << 20);
		endcase
		return p;
	endfunction

	// Valid stays high after an item so the next one can follow at once; the
	// sender drops it whenever it goes idle.
	task automatic send_item(input in_t p);
		int n;
		if (!quiet_tail && $urandom_range(0, 6) == 0) begin
			in_valid <= 0;
			n = $urandom_range(1, 4);
			repeat (n) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	task automatic directed_items();
		in_t p;
		p.ray_origin_packed = pack3(0, 0, 0);
		p.ray_direction_packed = unit_axis(0, 1);
		p.box_center_packed = pack3(2560, 0, 0);
		p.box_axis_x_packed = unit_axis(0, 1);
		p.box_axis_y_packed = unit_axis(1, 1);
		p.box_axis_z_packed = unit_axis(2, 1);
		p.box_low_corner_packed = pack3(-256, -256, -256);
		p.box_high_corner_packed = pack3(256, 256, 256);
		p.best_distance = DIST_MAX;
		send_item(p);
		// A closer hit already known, so the best distance stays.
		p.best_distance = 32'sd10;
		send_item(p);
		// Ray pointing away from the box.
		p.ray_direction_packed = unit_axis(0, -1);
		p.best_distance = DIST_MAX;
		send_item(p);
		// Parallel axes with the origin inside and outside the slab.
		p.ray_direction_packed = unit_axis(0, 1);
		p.box_center_packed = pack3(2560, 100, 0);
		send_item(p);
		p.box_center_packed = pack3(2560, 1000, 0);
		send_item(p);
		// Origin inside the box: entry clips to zero.
		p.box_center_packed = pack3(0, 0, 0);
		send_item(p);
		// Corners given in swapped order.
		p.box_center_packed = pack3(2560, 0, 0);
		p.box_low_corner_packed = pack3(256, 256, 256);
		p.box_high_corner_packed = pack3(-256, -256, -256);
		send_item(p);
		// Tiny direction makes the plane distances large.
		p.ray_direction_packed = pack3(17, 0, 0);
		p.box_low_corner_packed = pack3(-32768, -32768, -32768);
		p.box_high_corner_packed = pack3(32767, 32767, 32767);
		send_item(p);
		p.ray_direction_packed = pack3(-17, 0, 0);
		send_item(p);
		// Field extremes.
		p.ray_origin_packed = pack3(-32768, 32767, -32768);
		p.box_center_packed = pack3(32767, -32768, 32767);
		p.ray_direction_packed = pack3(-32768, -32768, 32767);
		p.box_axis_x_packed = pack3(-32768, -32768, -32768);
		p.box_axis_y_packed = pack3(32767, 32767, 32767);
		p.box_axis_z_packed = pack3(-32768, 32767, -32768);
		p.best_distance = DIST_MIN;
		send_item(p);
		p = '1;
		send_item(p);
		p = '0;
		send_item(p);
	endtask

	initial begin
		int phase;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_index = CFG_FAR_LIMIT;
		cfg_wdata = '0;
		quiet_tail = 0;
		hold_req = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		directed_items();
		drain();
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_reg(CFG_FAR_LIMIT, 31'h7FFF_FFFF);
					write_reg(CFG_PAR_THR, 15'd0);
				end
				1: begin
					write_reg(CFG_FAR_LIMIT, 31'd0);
					write_reg(CFG_PAR_THR, 15'd16384);
				end
				2: begin
					write_reg(CFG_FAR_LIMIT, 31'd600000);
					write_reg(CFG_PAR_THR, 15'd200);
				end
				3: begin
					write_reg(CFG_FAR_LIMIT, 31'h5555_5555);
					write_reg(CFG_PAR_THR, 15'h2AAA);
				end
				default: begin
					write_reg(CFG_FAR_LIMIT, FAR_RESET);
					write_reg(CFG_PAR_THR, THR_RESET);
				end
			endcase
			if (phase == 0)
				directed_items();
			for (int i = 0; i < RANDOM_ITEMS / 5; i++) begin
				if (phase == 1 && i == 50)
					hold_req = 1;
				if (phase == 4 && i == RANDOM_ITEMS / 10)
					quiet_tail = 1;
				// The sender pauses until every result has come back.
				if (phase == 2 && i == 100) begin
					in_valid <= 0;
					while (pending != 0)
						@(negedge clk);
				end
				send_item(make_pair());
			end
			drain();
		end

		$display("Covered %0d results, %0d hits, across five register settings.",
			results_seen, hits_seen);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Mismatches: %0d", fail_count);
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
